[rtl/htws_pkg.sv]
// Shared types and constants for the hysteresis turn wheel speed block.
// Holds mode codes, field widths and the configuration register map.
`timescale 1ns / 1ps
`default_nettype none

package htws_pkg;

    localparam int AngleW = 16;
    localparam int SpeedW = 16;
    localparam int ThreshW = 15;
    localparam int WheelW = 18;
    localparam int ModeW = 2;
    localparam int MagW = 17;
    localparam int ProdW = SpeedW + ThreshW;
    localparam int StepW = 4;

    localparam int InDataW = 32;
    localparam int OutDataW = 40;
    localparam int AddrW = 4;
    localparam int RegDataW = 32;

    typedef logic [ModeW-1:0] mode_t;

    localparam mode_t MODE_NONE = 2'd0;
    localparam mode_t MODE_SOFT = 2'd1;
    localparam mode_t MODE_HARD = 2'd2;

    // Register index taken from paddr[3:2]
    localparam logic [1:0] REG_MAX_SPEED = 2'd0;
    localparam logic [1:0] REG_HARD_THR = 2'd1;
    localparam logic [1:0] REG_SOFT_THR = 2'd2;
    localparam logic [1:0] REG_NO_THR = 2'd3;

    localparam logic [SpeedW-1:0] MAX_SPEED_RST = 16'd2560;
    localparam logic [ThreshW-1:0] HARD_THR_RST = 15'd16384;
    localparam logic [ThreshW-1:0] SOFT_THR_RST = 15'd12743;
    localparam logic [ThreshW-1:0] NO_THR_RST = 15'd1820;

endpackage

`default_nettype wire

[rtl/hysteresis_turn_wheel_speed_core.sv]
// Top level of the three-mode turning controller with hysteresis.
// Uses htws_pkg; contains the APB registers, a bit-serial multiplier and divider.
// In hard or straight mode the result goes from the input transaction directly to
// the output load; in soft mode it passes through 16 shift-add multiply steps, a
// dividend load, 16 restoring divide steps and the output load.
// One item is in work at a time; the next is taken once the current result is
// loaded into the output register.
// Reset (rst_n, asynchronous): mode straight, registers at their defaults,
// output register empty.
`timescale 1ns / 1ps
`default_nettype none

module hysteresis_turn_wheel_speed_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [15:0] heading_angle, [31:16] heading_length
    input  wire logic [htws_pkg::InDataW-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [17:0] left_speed, [35:18] right_speed, [37:36] turn_mode, [39:38] zero
    output logic [htws_pkg::OutDataW-1:0]      m_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [htws_pkg::AddrW-1:0]    paddr,
    input  wire logic [htws_pkg::RegDataW-1:0] pwdata,
    output logic [htws_pkg::RegDataW-1:0]      prdata,
    output logic                               pready
);
    import htws_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL = 2'd1;
    localparam logic [1:0] ST_DIV = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [SpeedW-1:0] max_speed_reg;
    logic [ThreshW-1:0] hard_thr_reg;
    logic [ThreshW-1:0] soft_thr_reg;
    logic [ThreshW-1:0] no_thr_reg;

    logic [1:0] state_reg, state_next;
    logic [StepW-1:0] cnt_reg;
    mode_t mode_reg;
    logic positive_reg;
    logic div_reg;
    logic fin_reg;
    logic [SpeedW-1:0] base_reg;
    logic [SpeedW-1:0] mplr_reg;
    logic [ProdW-1:0] acc_reg;
    logic [ThreshW-1:0] rem_reg;
    logic [SpeedW-1:0] lo_reg;

    logic m_tvalid_reg;
    logic [OutDataW-1:0] m_tdata_reg;

    logic cfg_wr;
    logic in_fire;
    logic load_out;

    logic [AngleW-1:0] angle;
    logic [SpeedW-1:0] length;
    logic neg;
    logic [MagW-1:0] mag;
    logic [MagW-1:0] hard_ext, soft_ext, no_ext;
    mode_t mode_a, mode_b, mode_next;
    logic [SpeedW-1:0] base_next;
    logic div_next;

    logic [SpeedW:0] trial;
    logic [SpeedW:0] diff;
    logic [SpeedW:0] outer_w, inner_w, hard_w;
    logic [WheelW-1:0] inner_s, outer_s, left_s, right_s;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_SPEED: prdata = {{(RegDataW-SpeedW){1'b0}}, max_speed_reg};
            REG_HARD_THR:  prdata = {{(RegDataW-ThreshW){1'b0}}, hard_thr_reg};
            REG_SOFT_THR:  prdata = {{(RegDataW-ThreshW){1'b0}}, soft_thr_reg};
            REG_NO_THR:    prdata = {{(RegDataW-ThreshW){1'b0}}, no_thr_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= MAX_SPEED_RST;
            hard_thr_reg <= HARD_THR_RST;
            soft_thr_reg <= SOFT_THR_RST;
            no_thr_reg <= NO_THR_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MAX_SPEED: max_speed_reg <= pwdata[SpeedW-1:0];
                REG_HARD_THR:  hard_thr_reg <= pwdata[ThreshW-1:0];
                REG_SOFT_THR:  soft_thr_reg <= pwdata[ThreshW-1:0];
                REG_NO_THR:    no_thr_reg <= pwdata[ThreshW-1:0];
                default:       max_speed_reg <= max_speed_reg;
            endcase
        end
    end

    // Input decode and mode update with hysteresis
    assign angle = s_tdata[AngleW-1:0];
    assign length = s_tdata[InDataW-1:AngleW];
    assign neg = angle[AngleW-1];
    assign mag = neg ? (MagW'(17'h10000) - {1'b0, angle}) : {1'b0, angle};
    assign hard_ext = {{(MagW-ThreshW){1'b0}}, hard_thr_reg};
    assign soft_ext = {{(MagW-ThreshW){1'b0}}, soft_thr_reg};
    assign no_ext = {{(MagW-ThreshW){1'b0}}, no_thr_reg};

    always_comb
    begin
        mode_a = mode_reg;
        if (mode_reg == MODE_HARD && mag <= soft_ext)
        begin
            mode_a = MODE_SOFT;
        end
        mode_b = mode_a;
        if (mode_a == MODE_SOFT)
        begin
            if (mag > hard_ext)
            begin
                mode_b = MODE_HARD;
            end
            else if (mag <= no_ext)
            begin
                mode_b = MODE_NONE;
            end
        end
        mode_next = mode_b;
        if (mode_b == MODE_NONE)
        begin
            if (mag > hard_ext)
            begin
                mode_next = MODE_HARD;
            end
            else if (mag > no_ext)
            begin
                mode_next = MODE_SOFT;
            end
        end
    end

    assign base_next = (length < max_speed_reg) ? length : max_speed_reg;
    assign div_next = (mode_next == MODE_SOFT) && (hard_thr_reg != '0) && (mag <= hard_ext);

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire = s_tvalid && s_tready;
    // Hold in DONE until the last divide step (if any) is held and the output register is free
    assign load_out = (state_reg == ST_DONE) && (fin_reg || !div_reg)
                      && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = div_next ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == '1)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '1)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            mode_reg <= MODE_NONE;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL || state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (in_fire)
            begin
                mode_reg <= mode_next;
            end
        end
    end

    // Restoring divide step: one quotient bit per cycle, shifted into lo_reg
    assign trial = {1'b0, rem_reg, lo_reg[SpeedW-1]};
    assign diff = trial - {2'b00, hard_thr_reg};

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    positive_reg <= !neg && (angle != '0);
                    div_reg <= div_next;
                    base_reg <= base_next;
                    mplr_reg <= mag[SpeedW-1:0];
                    acc_reg <= '0;
                end
            end
            ST_MUL:
            begin
                // Shift-add, multiplier bits MSB first
                acc_reg <= {acc_reg[ProdW-2:0], 1'b0}
                    + (mplr_reg[SpeedW-1] ? {{(ProdW-SpeedW){1'b0}}, base_reg} : '0);
                mplr_reg <= {mplr_reg[SpeedW-2:0], 1'b0};
                if (cnt_reg == '1)
                begin
                    rem_reg <= '0;
                    lo_reg <= '0;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    // Load dividend: high part below H, low part shifts out MSB first
                    rem_reg <= acc_reg[ProdW-1:SpeedW];
                    lo_reg <= acc_reg[SpeedW-1:0];
                end
            end
            default:
            begin
                positive_reg <= positive_reg;
            end
        endcase
        if (state_reg == ST_DIV && cnt_reg != '0)
        begin
            if (!diff[SpeedW])
            begin
                rem_reg <= diff[ThreshW-1:0];
                lo_reg <= {lo_reg[SpeedW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[ThreshW-1:0];
                lo_reg <= {lo_reg[SpeedW-2:0], 1'b0};
            end
        end
    end

    // Divide walks 15 steps after loading; run one extra step in DONE entry
    logic last_step;
    assign last_step = (state_reg == ST_DONE) && div_reg && !fin_reg;

    logic [ThreshW-1:0] rem_fin;
    logic [SpeedW-1:0] q_fin;
    assign rem_fin = !diff[SpeedW] ? diff[ThreshW-1:0] : trial[ThreshW-1:0];
    assign q_fin = {lo_reg[SpeedW-2:0], !diff[SpeedW]};

    logic [ThreshW-1:0] rem_hold_reg;
    logic [SpeedW-1:0] q_hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg <= 1'b0;
        end
        else if (state_reg != ST_DONE)
        begin
            fin_reg <= 1'b0;
        end
        else
        begin
            fin_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_step)
        begin
            rem_hold_reg <= rem_fin;
            q_hold_reg <= q_fin;
        end
    end

    // Result assembly; for a divide, only valid once the final divide step is held
    logic [ThreshW-1:0] rem_use;
    logic [SpeedW-1:0] q_use;
    assign rem_use = fin_reg ? rem_hold_reg : rem_fin;
    assign q_use = fin_reg ? q_hold_reg : q_fin;

    assign outer_w = {1'b0, base_reg} + {1'b0, q_use};
    assign inner_w = {1'b0, base_reg} - {1'b0, q_use} - {{SpeedW{1'b0}}, (rem_use != '0)};
    assign hard_w = {1'b0, max_speed_reg};

    always_comb
    begin
        if (mode_reg == MODE_HARD)
        begin
            inner_s = -{1'b0, hard_w};
            outer_s = {1'b0, hard_w};
        end
        else if (div_reg)
        begin
            inner_s = {1'b0, inner_w};
            outer_s = {1'b0, outer_w};
        end
        else
        begin
            inner_s = {2'b00, base_reg};
            outer_s = {2'b00, base_reg};
        end
        left_s = positive_reg ? inner_s : outer_s;
        right_s = positive_reg ? outer_s : inner_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (load_out && (fin_reg || !div_reg))
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out && (fin_reg || !div_reg))
        begin
            m_tdata_reg <= {2'b00, mode_reg, right_s, left_s};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

endmodule

`default_nettype wire

[verif/htws_wheel_checker.sv]
// Scoreboard for hysteresis_turn_wheel_speed_core: predicts turn mode and wheel speeds.
// Watches the input stream, the result stream and APB writes; depends on htws_pkg.
`timescale 1ns / 1ps

module htws_wheel_checker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    // [15:0] heading_angle, [31:16] heading_length
    input  wire logic [htws_pkg::InDataW-1:0]  s_tdata,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    // [17:0] left_speed, [35:18] right_speed, [37:36] turn_mode, [39:38] zero
    input  wire logic [htws_pkg::OutDataW-1:0] m_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic                          pready,
    input  wire logic [htws_pkg::AddrW-1:0]    paddr,
    input  wire logic [htws_pkg::RegDataW-1:0] pwdata,
    output int                                 mismatch_count,
    output int                                 pending_count
);

    import htws_pkg::*;

    typedef struct packed {
        logic [WheelW-1:0] left;
        logic [WheelW-1:0] right;
        mode_t             mode;
    } wheel_cmd_t;

    logic [SpeedW-1:0]  max_speed_cfg;
    logic [ThreshW-1:0] hard_thr_cfg;
    logic [ThreshW-1:0] soft_thr_cfg;
    logic [ThreshW-1:0] no_thr_cfg;
    mode_t              turn_mode_now;
    wheel_cmd_t         expected_wheel_q[$];
    int                 fails;

    // Update the hysteresis mode, then derive both wheel speeds.
    function automatic wheel_cmd_t predict_wheel_speeds(mode_t cur, logic [AngleW-1:0] angle,
                                                        logic [SpeedW-1:0] len);
        logic            positive;
        logic [MagW-1:0] mag;
        logic [SpeedW-1:0] base;
        mode_t           m;
        longint          inner;
        longint          outer;
        longint          h;
        longint          left;
        longint          right;
        wheel_cmd_t      r;
        positive = !angle[AngleW-1] && (angle != '0);
        mag = angle[AngleW-1] ? (17'h10000 - {1'b0, angle}) : {1'b0, angle};
        base = (len < max_speed_cfg) ? len : max_speed_cfg;
        m = cur;
        if (m == MODE_HARD && mag <= soft_thr_cfg)
            m = MODE_SOFT;
        if (m == MODE_SOFT)
        begin
            if (mag > hard_thr_cfg)
                m = MODE_HARD;
            else if (mag <= no_thr_cfg)
                m = MODE_NONE;
        end
        if (m == MODE_NONE)
        begin
            if (mag > hard_thr_cfg)
                m = MODE_HARD;
            else if (mag > no_thr_cfg)
                m = MODE_SOFT;
        end
        h = longint'(hard_thr_cfg);
        if (m == MODE_HARD)
        begin
            inner = -longint'(max_speed_cfg);
            outer = longint'(max_speed_cfg);
        end
        else if (m == MODE_SOFT && h != 0 && mag <= hard_thr_cfg)
        begin
            inner = (longint'(base) * (h - longint'(mag))) / h;
            outer = longint'(base) + (longint'(base) * longint'(mag)) / h;
        end
        else
        begin
            inner = longint'(base);
            outer = longint'(base);
        end
        // Positive angle turns left, so the left wheel is the inner one.
        left = positive ? inner : outer;
        right = positive ? outer : inner;
        r.left = left[WheelW-1:0];
        r.right = right[WheelW-1:0];
        r.mode = m;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wheel_cmd_t exp_cmd;
        logic [WheelW-1:0] got_left;
        logic [WheelW-1:0] got_right;
        mode_t got_mode;
        logic [1:0] got_pad;
        if (!rst_n)
        begin
            max_speed_cfg <= MAX_SPEED_RST;
            hard_thr_cfg <= HARD_THR_RST;
            soft_thr_cfg <= SOFT_THR_RST;
            no_thr_cfg <= NO_THR_RST;
            turn_mode_now = MODE_NONE;
            expected_wheel_q.delete();
            fails = 0;
            mismatch_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_MAX_SPEED: max_speed_cfg <= pwdata[SpeedW-1:0];
                    REG_HARD_THR:  hard_thr_cfg <= pwdata[ThreshW-1:0];
                    REG_SOFT_THR:  soft_thr_cfg <= pwdata[ThreshW-1:0];
                    REG_NO_THR:    no_thr_cfg <= pwdata[ThreshW-1:0];
                    default: ;
                endcase
            end
            // Retire the result first: a result never belongs to the input taken at the same edge.
            if (m_tvalid && m_tready)
            begin
                got_left = m_tdata[17:0];
                got_right = m_tdata[35:18];
                got_mode = m_tdata[37:36];
                got_pad = m_tdata[39:38];
                if (expected_wheel_q.size() == 0)
                begin
                    fails = fails + 1;
                    if (fails <= 10)
                        $display("unexpected result transaction: left %0d right %0d mode %0d",
                                 $signed(got_left), $signed(got_right), got_mode);
                end
                else
                begin
                    exp_cmd = expected_wheel_q.pop_front();
                    if (got_left !== exp_cmd.left || got_right !== exp_cmd.right ||
                        got_mode !== exp_cmd.mode || got_pad !== 2'b00)
                    begin
                        fails = fails + 1;
                        if (fails <= 10)
                            $display("mismatch: expected left %0d right %0d mode %0d, got left %0d right %0d mode %0d pad %0d",
                                     $signed(exp_cmd.left), $signed(exp_cmd.right), exp_cmd.mode,
                                     $signed(got_left), $signed(got_right), got_mode, got_pad);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                exp_cmd = predict_wheel_speeds(turn_mode_now, s_tdata[15:0], s_tdata[31:16]);
                turn_mode_now = exp_cmd.mode;
                expected_wheel_q.push_back(exp_cmd);
            end
            pending_count <= expected_wheel_q.size();
            mismatch_count <= fails;
        end
    end

endmodule

[verif/tb_hysteresis_turn_wheel_speed_core.sv]
// Testbench top for hysteresis_turn_wheel_speed_core: headings, threshold setups, verdict.
// Depends on htws_pkg, the core and htws_wheel_checker.
`timescale 1ns / 1ps

module tb_hysteresis_turn_wheel_speed_core;

    import htws_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DIRECTED_N = 23;
    localparam int SETTLE_CYCLES = 40;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_HOLD} ready_pattern_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [AddrW-1:0]    paddr = '0;
    logic [RegDataW-1:0] pwdata = '0;
    logic [RegDataW-1:0] prdata;
    logic                pready;
    int                  mismatch_total;
    int                  pending_total;
    int                  cycle_count = 0;

    // Stimulus-side copy of the limits, used only to aim angles and lengths.
    logic [SpeedW-1:0]  cfg_max = MAX_SPEED_RST;
    logic [ThreshW-1:0] cfg_hard = HARD_THR_RST;
    logic [ThreshW-1:0] cfg_soft = SOFT_THR_RST;
    logic [ThreshW-1:0] cfg_no = NO_THR_RST;

    int             burst_left = 0;
    int             sweep_mag = 0;
    logic           sweep_up = 1'b1;
    ready_pattern_t ready_pattern = READY_ALWAYS;
    int             ready_left = 0;

    logic [AngleW-1:0] dir_angle [DIRECTED_N] = '{
        16'd0, 16'd0, 16'd1820, 16'd1821, -16'sd1821, 16'd16384, 16'd16385, 16'd12744,
        -16'sd12743, 16'h8000, 16'd32767, 16'd0, 16'd8000, -16'sd8000, 16'd1820, 16'd20000,
        16'd13000, 16'd5000, 16'd0, 16'hFFFF, 16'd32767, -16'sd32767, -16'sd16384};
    logic [SpeedW-1:0] dir_length [DIRECTED_N] = '{
        16'd0, 16'hFFFF, 16'd2560, 16'd1000, 16'd2559, 16'd2561, 16'd500, 16'hFFFF,
        16'd2560, 16'd100, 16'hFFFF, 16'd0, 16'hFFFF, 16'd12345, 16'd7, 16'd2560,
        16'd1, 16'd40000, 16'd2560, 16'd1, 16'd0, 16'hFFFF, 16'd2560};

    hysteresis_turn_wheel_speed_core DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    htws_wheel_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_total),
        .pending_count  (pending_total)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver back-pressure: switch at random between stall patterns.
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_pattern = ready_pattern_t'($urandom_range(0, 3));
            ready_left = (ready_pattern == READY_HOLD) ? $urandom_range(1, 30)
                                                       : $urandom_range(8, 120);
        end
        ready_left = ready_left - 1;
        case (ready_pattern)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            READY_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
            default:      m_tready <= 1'b0;
        endcase
    end

    function automatic logic [AngleW-1:0] pick_angle();
        int mag;
        int jitter;
        int stepv;
        logic [31:0] raw;
        jitter = $urandom_range(0, 6);
        case ($urandom_range(0, 9))
            0:
            begin
                raw = $urandom;
                return raw[AngleW-1:0];
            end
            1:       mag = ($urandom_range(0, 1) == 1) ? 32768 : $urandom_range(0, 2);
            2, 3:    mag = int'(cfg_hard) + jitter - 3;
            4, 5:    mag = int'(cfg_soft) + jitter - 3;
            6, 7:    mag = int'(cfg_no) + jitter - 3;
            default:
            begin
                // Sweep the magnitude up and down to walk the hysteresis loop.
                stepv = $urandom_range(0, 1500);
                sweep_mag = sweep_up ? sweep_mag + stepv : sweep_mag - stepv;
                if (sweep_mag >= 32768)
                begin
                    sweep_mag = 32768;
                    sweep_up = 1'b0;
                end
                else if (sweep_mag <= 0)
                begin
                    sweep_mag = 0;
                    sweep_up = 1'b1;
                end
                mag = sweep_mag;
            end
        endcase
        if (mag < 0)
            mag = 0;
        if (mag > 32768)
            mag = 32768;
        if (mag != 32768 && $urandom_range(0, 1) == 1)
            mag = -mag;
        raw = mag;
        return raw[AngleW-1:0];
    endfunction

    function automatic logic [SpeedW-1:0] pick_length();
        int len;
        logic [31:0] raw;
        case ($urandom_range(0, 7))
            0:       len = 0;
            1:       len = 65535;
            2:       len = int'(cfg_max) + $urandom_range(0, 4) - 2;
            3:       len = $urandom_range(0, cfg_max);
            default: len = $urandom_range(0, 65535);
        endcase
        if (len < 0)
            len = 0;
        if (len > 65535)
            len = 65535;
        raw = len;
        return raw[SpeedW-1:0];
    endfunction

    task automatic send_heading(input logic [AngleW-1:0] angle, input logic [SpeedW-1:0] len);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
        end
        s_tdata <= {len, angle};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left = burst_left - 1;
    endtask

    // Hold off until every expected result has come back, then let the core settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_total != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [RegDataW-1:0] value);
        paddr <= {index, 2'b00};
        pwdata <= value;
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Upper bits carry noise; the core must keep only each register's width.
    task automatic program_limits(input logic [SpeedW-1:0] top_speed,
                                  input logic [ThreshW-1:0] hard,
                                  input logic [ThreshW-1:0] soft_thr,
                                  input logic [ThreshW-1:0] none);
        logic [31:0] noise;
        noise = $urandom;
        write_register(REG_MAX_SPEED, {noise[31:16], top_speed});
        noise = $urandom;
        write_register(REG_HARD_THR, {noise[31:15], hard});
        noise = $urandom;
        write_register(REG_SOFT_THR, {noise[31:15], soft_thr});
        noise = $urandom;
        write_register(REG_NO_THR, {noise[31:15], none});
        cfg_max = top_speed;
        cfg_hard = hard;
        cfg_soft = soft_thr;
        cfg_no = none;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_heading(pick_angle(), pick_length());
        drain_results();
    endtask

    initial
    begin
        logic [31:0] rnd [4];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            send_heading(dir_angle[i], dir_length[i]);
        drain_results();
        run_random(150);

        program_limits(16'hFFFF, 15'h7FFF, 15'h7FFF, 15'd0);
        run_random(150);
        program_limits(16'd0, 15'd0, 15'd0, 15'd0);
        run_random(120);
        // Thresholds out of order: no-turn above hard.
        program_limits(16'd1, 15'd1, 15'd0, 15'h7FFF);
        run_random(120);
        program_limits(16'd300, 15'd4000, 15'd9000, 15'd2000);
        run_random(150);
        repeat (3)
        begin
            foreach (rnd[k])
                rnd[k] = $urandom;
            program_limits(rnd[0][15:0], rnd[1][14:0], rnd[2][14:0], rnd[3][14:0]);
            run_random(120);
        end

        if (mismatch_total == 0 && pending_total == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
